FILE: rtl/core/locality_improved_string_kernel_unit_macros.svh
// Assertion macros used by the kernel unit checker.
`ifndef LOCALITY_IMPROVED_STRING_KERNEL_UNIT_MACROS_SVH
`define LOCALITY_IMPROVED_STRING_KERNEL_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LISK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kernel unit check failed");

// Next-cycle implication, disabled in reset.
`define LISK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kernel unit check failed");

`endif

FILE: rtl/core/lisk_pkg.sv
// Constants shared by the string kernel unit and its checker.
`timescale 1ns / 1ps
package lisk_pkg;
  localparam int MAX_WINDOW_HALF = 16;
  localparam int MAX_STRING_LEN  = 4096;
  localparam int ADDR_W   = $clog2(MAX_STRING_LEN);
  localparam int POS_W    = ADDR_W + 1;
  localparam int L_W      = 5;
  localparam int LE_W     = $clog2(MAX_WINDOW_HALF + 1);
  localparam int PW_W     = 3;
  localparam int KV_W     = 63;
  localparam int Q_FRAC   = 32;
  localparam int W_W      = Q_FRAC + 1;
  localparam int ACC_W    = ADDR_W + W_W;
  localparam int D_W      = $clog2(2 * MAX_WINDOW_HALF + 2);
  localparam int WT_W     = $clog2(MAX_WINDOW_HALF + 2);
  localparam int NUM_W    = $clog2((MAX_WINDOW_HALF + 1) * (MAX_WINDOW_HALF + 1) + 1);
  localparam int DEN_W    = $clog2((2 * MAX_WINDOW_HALF + 1) * (MAX_WINDOW_HALF + 1) + 1);
  localparam int DVD_W    = NUM_W + Q_FRAC;
  localparam int REM_W    = DEN_W + 1;
  localparam int DCNT_W   = $clog2(DVD_W + 1);
  localparam int F_W      = KV_W + ACC_W + 1;
  localparam int SUM_W    = POS_W + 2;

  localparam logic [1:0] REG_WINDOW_HALF = 2'd0;
  localparam logic [1:0] REG_INNER_POW   = 2'd1;
  localparam logic [1:0] REG_OUTER_POW   = 2'd2;

  localparam logic [KV_W-1:0] Q_MAX = '1;
endpackage

FILE: rtl/core/lisk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lisk_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/locality_improved_string_kernel_unit.sv
// Top level of the locality-improved string kernel unit.
`timescale 1ns / 1ps
// Feed two equal-length strings as character pairs: one pair transfers at each
// rising edge with start high and busy low. Each pair stores a match bit in the
// history RAM (pairs beyond 4096 are dropped). The pair with last_pair raises
// busy while the kernel is evaluated from the history RAM, one bit read per
// cycle. Each window start goes through setup and window sum, bit-serial
// division, closing the inner power and the inner multiplies on the shared
// 32x32 multiplier; the outer multiplies follow once all windows are done.
// The result then shows on kernel_value/saturated for exactly one cycle with
// done high; the receiver cannot stall it, so capture it on that cycle.
// kernel_value is unsigned Q31.32 clipped at 2^63-1, with saturated flagging
// the clip. The history RAM needs no clearing after reset. Write configuration
// only while busy is low.
module locality_improved_string_kernel_unit import lisk_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [7:0]      left_char,
  input  logic [7:0]      right_char,
  input  logic            last_pair,
  output logic            done,
  output logic [KV_W-1:0] kernel_value,
  output logic            saturated,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_WIN  = 10'b0000000010,
    S_SUM  = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_IPOW = 10'b0000010000,
    S_IMUL = 10'b0000100000,
    S_IRND = 10'b0001000000,
    S_OCHK = 10'b0010000000,
    S_OMUL = 10'b0100000000,
    S_OFIN = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [L_W-1:0]  window_half;
  logic [PW_W-1:0] inner_power_less_one;
  logic [PW_W-1:0] outer_power_less_one;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             in_xfer;
  logic             pos_room;

  // Kernel datapath
  logic [LE_W-1:0]  l_eff;
  logic [LE_W-1:0]  l_clamp;
  logic [DEN_W-1:0] den;
  logic [POS_W-1:0] n;
  logic [POS_W-1:0] t;
  logic [D_W-1:0]   d;
  logic [D_W-1:0]   d_pend;
  logic             pend;
  logic [NUM_W-1:0] num;
  logic [DVD_W-1:0] dvd;
  logic [REM_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DCNT_W-1:0] dcnt;
  logic [W_W-1:0]   w;
  logic [W_W-1:0]   p;
  logic [PW_W-1:0]  icnt;
  logic [ACC_W-1:0] acc;
  logic [KV_W-1:0]  r;
  logic             sat;
  logic [PW_W-1:0]  ocnt;
  logic [F_W-1:0]   f;
  logic [2:0]       ph;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;

  logic             hist_bit;
  logic [ADDR_W-1:0] rd_addr;

  // Window sum terms for the bit read last cycle
  logic [SUM_W-1:0] td;
  logic [WT_W-1:0]  wt;
  logic             incl;
  logic [REM_W-1:0] rem_sh;
  logic             ge;
  logic [DVD_W-1:0] quo_next;
  logic [6:0]       f_sh;

  assign busy     = (state != S_IDLE);
  assign pready   = 1'b1;
  assign in_xfer  = start && !busy;
  assign pos_room = (pos < POS_W'(MAX_STRING_LEN));
  assign pos_next = pos_room ? pos + 1'b1 : pos;
  assign l_clamp  = (window_half > L_W'(MAX_WINDOW_HALF)) ? LE_W'(MAX_WINDOW_HALF)
                                                          : LE_W'(window_half);
  assign rd_addr  = ADDR_W'(t + POS_W'(d));

  lisk_ram #(
    .WIDTH (1),
    .DEPTH (MAX_STRING_LEN)
  ) u_hist (
    .clk   (clk),
    .we    (in_xfer && pos_room),
    .waddr (pos[ADDR_W-1:0]),
    .wdata (left_char == right_char),
    .raddr (rd_addr),
    .rdata (hist_bit)
  );

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_HALF: prdata = 32'(window_half);
      REG_INNER_POW:   prdata = 32'(inner_power_less_one);
      REG_OUTER_POW:   prdata = 32'(outer_power_less_one);
      default:         prdata = 32'd0;
    endcase
  end

  // Triangular weight: rising on the left, peak at the centre, falling on the
  // right. Left terms drop out once their paired right index passes the end.
  always_comb begin
    td = SUM_W'(t) + SUM_W'(d_pend);
    if (d_pend < D_W'(l_eff)) begin
      incl = (td + SUM_W'(l_eff) + 1'b1) < SUM_W'(n);
      wt   = WT_W'(d_pend) + 1'b1;
    end else if (d_pend == D_W'(l_eff)) begin
      incl = 1'b1;
      wt   = WT_W'(l_eff) + 1'b1;
    end else begin
      incl = td < SUM_W'(n);
      wt   = WT_W'((D_W'(l_eff) << 1) + 1'b1 - d_pend);
    end
  end

  // One restoring division step per cycle
  always_comb begin
    rem_sh   = {rem[DEN_W-1:0], dvd[DVD_W-1]};
    ge       = rem_sh >= REM_W'(den);
    quo_next = {quo[DVD_W-2:0], ge};
  end

  // Shared multiplier operand select; outer product goes in four partials
  always_comb begin
    mul_a = p[31:0];
    mul_b = w[31:0];
    f_sh  = 7'd0;
    if (state == S_OMUL) begin
      unique case (ph)
        3'd0:    begin mul_a = r[31:0];              mul_b = acc[31:0]; end
        3'd1:    begin mul_a = r[31:0];              mul_b = 32'(acc[ACC_W-1:32]); end
        3'd2:    begin mul_a = 32'(r[KV_W-1:32]);    mul_b = acc[31:0]; end
        3'd3:    begin mul_a = 32'(r[KV_W-1:32]);    mul_b = 32'(acc[ACC_W-1:32]); end
        default: begin mul_a = 32'd0;                mul_b = 32'd0; end
      endcase
      // shift of the partial registered in the previous phase
      unique case (ph)
        3'd2, 3'd3: f_sh = 7'd32;
        3'd4:       f_sh = 7'd64;
        default:    f_sh = 7'd0;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      pos                  <= '0;
      done                 <= 1'b0;
      window_half          <= L_W'(3);
      inner_power_less_one <= PW_W'(2);
      outer_power_less_one <= PW_W'(0);
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_WINDOW_HALF: window_half          <= pwdata[L_W-1:0];
          REG_INNER_POW:   inner_power_less_one <= pwdata[PW_W-1:0];
          REG_OUTER_POW:   outer_power_less_one <= pwdata[PW_W-1:0];
          default:         ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            pos <= pos_next;
            if (last_pair) begin
              state <= S_WIN;
            end
          end
        end
        S_WIN: begin
          if ((SUM_W'(t) + SUM_W'(l_eff)) < SUM_W'(n)) begin
            state <= S_SUM;
          end else begin
            state <= S_OCHK;
          end
        end
        S_SUM: begin
          if (d > (D_W'(l_eff) << 1) && !pend) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == DCNT_W'(DVD_W - 1)) begin
            state <= S_IPOW;
          end
        end
        S_IPOW: begin
          if (icnt == inner_power_less_one || w[Q_FRAC]) begin
            state <= S_WIN;
          end else begin
            state <= S_IMUL;
          end
        end
        S_IMUL: state <= S_IRND;
        S_IRND: state <= S_IPOW;
        S_OCHK: begin
          if (ocnt == outer_power_less_one || sat) begin
            // emit the result and clear for the next string pair
            done  <= 1'b1;
            pos   <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_OMUL;
          end
        end
        S_OMUL: begin
          if (ph == 3'd4) begin
            state <= S_OFIN;
          end
        end
        S_OFIN: state <= S_OCHK;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        // latch the window geometry for this string
        l_eff <= l_clamp;
        den   <= DEN_W'(((LE_W + 1)'(l_clamp) << 1) + 1'b1) * DEN_W'(l_clamp + 1'b1);
        n     <= pos_next;
        t     <= '0;
        acc   <= '0;
      end
      S_WIN: begin
        d    <= '0;
        pend <= 1'b0;
        num  <= '0;
        r    <= KV_W'(acc);
        sat  <= 1'b0;
        ocnt <= '0;
      end
      S_SUM: begin
        if (pend && incl && hist_bit) begin
          num <= num + NUM_W'(wt);
        end
        if (d <= (D_W'(l_eff) << 1)) begin
          pend   <= 1'b1;
          d_pend <= d;
          d      <= d + 1'b1;
        end else begin
          pend <= 1'b0;
        end
        // load the dividend with the rounding half already added
        dvd  <= {num, Q_FRAC'(0)} + DVD_W'(den >> 1);
        rem  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        rem  <= ge ? rem_sh - REM_W'(den) : rem_sh;
        quo  <= quo_next;
        dvd  <= dvd << 1;
        dcnt <= dcnt + 1'b1;
        w    <= quo_next[W_W-1:0];
        p    <= quo_next[W_W-1:0];
        icnt <= '0;
      end
      S_IPOW: begin
        if (icnt == inner_power_less_one || w[Q_FRAC]) begin
          acc <= acc + ACC_W'(p);
          t   <= t + 1'b1;
        end
      end
      S_IMUL: ;
      S_IRND: begin
        p    <= W_W'((prod + 64'h8000_0000) >> Q_FRAC);
        icnt <= icnt + 1'b1;
      end
      S_OCHK: begin
        kernel_value <= r;
        saturated    <= sat;
        f            <= F_W'(64'h8000_0000);
        ph           <= '0;
      end
      S_OMUL: begin
        if (ph != 3'd0) begin
          f <= f + (F_W'(prod) << f_sh);
        end
        ph <= ph + 1'b1;
      end
      S_OFIN: begin
        if (|f[F_W-1:KV_W+Q_FRAC]) begin
          sat <= 1'b1;
          r   <= Q_MAX;
        end else begin
          r <= f[KV_W+Q_FRAC-1:Q_FRAC];
        end
        ocnt <= ocnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/lisk_checker.sv
// Port-level checker for the string kernel unit and its bind.
`timescale 1ns / 1ps
`include "locality_improved_string_kernel_unit_macros.svh"
module lisk_checker import lisk_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            last_pair,
  input logic            done,
  input logic            saturated,
  input logic [KV_W-1:0] kernel_value
);
  `LISK_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy))
  `LISK_ASSERT_NEXT(a_last_goes_busy, clk, rst, start && !busy && last_pair, busy)
  `LISK_ASSERT_NEXT(a_pair_no_result, clk, rst, start && !busy && !last_pair, !busy && !done)
  `LISK_ASSERT_NOW(a_sat_is_max, clk, rst, done && saturated, &kernel_value)
  `LISK_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
endmodule

bind locality_improved_string_kernel_unit lisk_checker u_lisk_checker (.*);
